>>> hw/rtl/des_pkg.sv
// ----------------------------------------------------------------------------
// des_pkg
// tables and bit-level functions for the des encryption pipeline: the
// permutations, the key schedule steps and the round function
// ----------------------------------------------------------------------------
package des_pkg;

    localparam int unsigned NUM_ROUNDS = 16;

    localparam logic [1:0] ROT_TAB [NUM_ROUNDS] = '{
        2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
    };

    localparam logic [6:0] PC1_TAB [56] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50,
        7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35,
        7'd27, 7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55,
        7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,  7'd62, 7'd54, 7'd46, 7'd38,
        7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21,
        7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
    };

    localparam logic [6:0] PC2_TAB [48] = '{
        7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,  7'd3,  7'd28, 7'd15, 7'd6,
        7'd21, 7'd10, 7'd23, 7'd19, 7'd12, 7'd4,  7'd26, 7'd8,  7'd16, 7'd7,
        7'd27, 7'd20, 7'd13, 7'd2,  7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55,
        7'd30, 7'd40, 7'd51, 7'd45, 7'd33, 7'd48, 7'd44, 7'd49, 7'd39, 7'd56,
        7'd34, 7'd53, 7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32
    };

    localparam logic [6:0] IP_TAB [64] = '{
        7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
        7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
        7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
        7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
    };

    localparam logic [6:0] FP_TAB [64] = '{
        7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
        7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
        7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
        7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
        7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
        7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
        7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
        7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
    };

    localparam logic [5:0] E_TAB [48] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
        6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
        6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
        6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
        6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
    };

    localparam logic [5:0] P_TAB [32] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    localparam logic [3:0] SBOX_TAB [8][64] = '{
        '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
          4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
          4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
          4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
          4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
          4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
          4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
          4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
        '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
          4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
          4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
          4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
          4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
          4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
          4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
          4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
        '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
          4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
          4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
          4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
          4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
          4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
          4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
          4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
        '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
          4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
          4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
          4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
          4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
          4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
          4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
          4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
        '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
          4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
          4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
          4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
          4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
          4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
          4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
          4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
        '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
          4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
          4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
          4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
          4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
          4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
          4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
          4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
        '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
          4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
          4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
          4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
          4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
          4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
          4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
          4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
        '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
          4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
          4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
          4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
          4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
          4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
          4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
          4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}
    };

    // output bit i (msb first) takes input bit tab[i] (1-based, msb first)
    function automatic logic [55:0] perm_pc1(input logic [63:0] x);
        logic [55:0] r;
        for (int i = 0; i < 56; i++)
        begin
            r[55 - i] = x[64 - int'(PC1_TAB[i])];
        end
        return r;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] x);
        logic [47:0] r;
        for (int i = 0; i < 48; i++)
        begin
            r[47 - i] = x[56 - int'(PC2_TAB[i])];
        end
        return r;
    endfunction

    function automatic logic [63:0] perm_ip(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 64; i++)
        begin
            r[63 - i] = x[64 - int'(IP_TAB[i])];
        end
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 64; i++)
        begin
            r[63 - i] = x[64 - int'(FP_TAB[i])];
        end
        return r;
    endfunction

    function automatic logic [27:0] rotl28(input logic [27:0] v, input logic [1:0] s);
        logic [27:0] r;
        if (s == 2'd2)
        begin
            r = {v[25:0], v[27:26]};
        end
        else
        begin
            r = {v[26:0], v[27]};
        end
        return r;
    endfunction

    // feistel function: expansion, key mix, s-boxes, p permutation
    function automatic logic [31:0] des_f(input logic [31:0] half, input logic [47:0] rk);
        logic [47:0] x;
        logic [31:0] s;
        logic [31:0] r;
        logic [5:0]  six;
        for (int i = 0; i < 48; i++)
        begin
            x[47 - i] = half[32 - int'(E_TAB[i])];
        end
        x = x ^ rk;
        for (int b = 0; b < 8; b++)
        begin
            six = x[47 - 6 * b -: 6];
            s[31 - 4 * b -: 4] = SBOX_TAB[b][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++)
        begin
            r[31 - i] = s[32 - int'(P_TAB[i])];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/des_block_encrypt_top.sv
// ----------------------------------------------------------------------------
// des_block_encrypt_top
// des encryption of 64-bit blocks under a 64-bit key, one round per stage
// ----------------------------------------------------------------------------
// One block enters per clock while in_stall is low; its ciphertext passes an
// input stage holding the initially permuted block, then one register stage
// for each of the sixteen feistel rounds; the inverse permutation is wiring on
// the last stage. Each stage holds its block only while the stage after it is
// full, so empty slots are squeezed out and out_stall reaches in_stall only
// when all seventeen stages are occupied. The round keys are derived directly
// from the key register (wiring only), so cipher_key must be written while
// no transaction is in flight; cfg_ready is always high.
// ----------------------------------------------------------------------------
module des_block_encrypt_top
    import des_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cipher_key,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] plain_block,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] cipher_block
);

    localparam int unsigned LAST = NUM_ROUNDS;

    logic [63:0] key_reg;
    logic [27:0] c_sched [NUM_ROUNDS + 1];
    logic [27:0] d_sched [NUM_ROUNDS + 1];
    logic [47:0] rkey    [NUM_ROUNDS];

    logic [63:0] data_reg  [LAST + 1];
    logic [63:0] data_next [LAST + 1];
    logic [LAST:0] valid_reg;
    logic [LAST:0] adv;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            key_reg <= cipher_key;
        end
    end

    // key schedule: fixed rotations and selections, no gates
    assign {c_sched[0], d_sched[0]} = perm_pc1(key_reg);

    genvar g;
    generate
        for (g = 0; g < NUM_ROUNDS; g++)
        begin : g_key
            assign c_sched[g + 1] = rotl28(c_sched[g], ROT_TAB[g]);
            assign d_sched[g + 1] = rotl28(d_sched[g], ROT_TAB[g]);
            assign rkey[g]        = perm_pc2({c_sched[g + 1], d_sched[g + 1]});
        end
    endgenerate

    // a stage may load when it is empty or its content moves on
    assign adv[LAST] = !valid_reg[LAST] || !out_stall;
    generate
        for (g = 0; g < LAST; g++)
        begin : g_adv
            assign adv[g] = !valid_reg[g] || adv[g + 1];
        end
    endgenerate

    assign in_stall = !adv[0];

    assign data_next[0] = perm_ip(plain_block);
    generate
        for (g = 1; g <= LAST; g++)
        begin : g_round
            assign data_next[g] = {data_reg[g - 1][31:0],
                                   data_reg[g - 1][63:32]
                                   ^ des_f(data_reg[g - 1][31:0], rkey[g - 1])};
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (adv[0])
        begin
            valid_reg[0] <= in_valid;
        end
    end

    generate
        for (g = 1; g <= LAST; g++)
        begin : g_valid
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[g] <= 1'b0;
                end
                else if (adv[g])
                begin
                    valid_reg[g] <= valid_reg[g - 1];
                end
            end
        end
    endgenerate

    generate
        for (g = 0; g <= LAST; g++)
        begin : g_data
            always_ff @(posedge clk)
            begin
                if (adv[g])
                begin
                    data_reg[g] <= data_next[g];
                end
            end
        end
    endgenerate

    assign out_valid    = valid_reg[LAST];
    assign cipher_block = perm_fp({data_reg[LAST][31:0], data_reg[LAST][63:32]});

    // input held off only when every stage is full and the output is stalled
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ((&valid_reg) && out_stall))
        else $error("input stalled with an empty stage in the pipeline");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> valid_reg[0])
        else $error("accepted transaction did not enter the input stage");

    a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[8] && !adv[8]) |=> (valid_reg[8] && $stable(data_reg[8])))
        else $error("blocked middle stage lost or changed its block");

    a_last_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[LAST - 1] && adv[LAST]) |=> valid_reg[LAST])
        else $error("block from the last round stage was dropped");

endmodule
